### rtl/alu_fm_pkg.sv
// ----------------------------------------------------------------------------
// alu_fm_pkg
// Types and codes shared by the ALU with masked flag update.
// ----------------------------------------------------------------------------
package alu_fm_pkg;

    // operation codes
    localparam logic [2:0] OP_ADD8  = 3'd0;
    localparam logic [2:0] OP_SUB8  = 3'd1;
    localparam logic [2:0] OP_ADD16 = 3'd2;
    localparam logic [2:0] OP_SUB16 = 3'd3;
    localparam logic [2:0] OP_RL8   = 3'd4;
    localparam logic [2:0] OP_RR8   = 3'd5;

    // flag bits
    localparam logic [7:0] FL_C  = 8'h01;
    localparam logic [7:0] FL_N  = 8'h02;
    localparam logic [7:0] FL_PV = 8'h04;
    localparam logic [7:0] FL_H  = 8'h10;
    localparam logic [7:0] FL_Z  = 8'h40;
    localparam logic [7:0] FL_S  = 8'h80;

    localparam logic [7:0] FL_ALL8  = FL_C | FL_N | FL_PV | FL_H | FL_Z | FL_S;
    localparam logic [7:0] FL_CNH   = FL_C | FL_N | FL_H;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic        fill_bit;
        logic [7:0]  flag_mask;
        logic [7:0]  flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  flags_out;
    } t_alu_out;

endpackage

### rtl/cpu_alu_with_flag_mask.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flag_mask
// ALU step for an 8-bit processor: add/sub in 8 and 16 bits and 8-bit
// rotates through a fill bit, with a masked update of the flag byte.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_stall carry one t_alu_in beat
//   output channel o_out_valid / i_out_stall carry one t_alu_out beat
//   a beat moves at an edge where valid is high and stall is low
// Path: a taken input beat goes into the input register, through the single
//   pass of adder/flag logic, then into the result register.
// Throughput: one beat per cycle while the output is not stalled; the rate is
//   set by the single adder pass between the two registers.
// Reset: synchronous active low; both stages empty, o_out_valid low.
// Receiver stall: the result register holds its beat; the input register
//   still takes a beat if it is empty, and o_in_stall rises only when both
//   stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module cpu_alu_with_flag_mask (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  alu_fm_pkg::t_alu_in   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output alu_fm_pkg::t_alu_out  o_out
);
    import alu_fm_pkg::*;

    logic     r_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;

    logic     adv_out;
    logic     adv_in;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [8:0]  sum8;
    logic [8:0]  dif8;
    logic [4:0]  sum4;
    logic [4:0]  dif4;
    logic [16:0] sum16;
    logic [16:0] dif16;
    logic [12:0] sum12;
    logic [12:0] dif12;
    logic [15:0] res;
    logic [7:0]  nf;
    logic [7:0]  touched;
    logic [7:0]  upd;

    assign adv_out    = !(r_out_valid && i_out_stall);
    assign adv_in     = adv_out || !r_in_valid;
    assign o_in_stall = !adv_in;

    assign a8 = r_in.operand_a[7:0];
    assign b8 = r_in.operand_b[7:0];

    assign sum8  = {1'b0, a8} + {1'b0, b8};
    assign dif8  = {1'b0, a8} - {1'b0, b8};
    assign sum4  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
    assign dif4  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]};
    assign sum16 = {1'b0, r_in.operand_a} + {1'b0, r_in.operand_b};
    assign dif16 = {1'b0, r_in.operand_a} - {1'b0, r_in.operand_b};
    assign sum12 = {1'b0, r_in.operand_a[11:0]} + {1'b0, r_in.operand_b[11:0]};
    assign dif12 = {1'b0, r_in.operand_a[11:0]} - {1'b0, r_in.operand_b[11:0]};

    always_comb begin
        res     = 16'h0000;
        nf      = 8'h00;
        touched = 8'h00;
        case (r_in.operation)
            OP_ADD8: begin
                res = {8'h00, sum8[7:0]};
                if (sum8[8]) nf = nf | FL_C;
                if (sum4[4]) nf = nf | FL_H;
                if ((a8[7] == b8[7]) && (sum8[7] != a8[7])) nf = nf | FL_PV;
                if (sum8[7]) nf = nf | FL_S;
                if (sum8[7:0] == 8'h00) nf = nf | FL_Z;
                touched = FL_ALL8;
            end
            OP_SUB8: begin
                res = {8'h00, dif8[7:0]};
                // borrow shows up as the extra top bit of the difference
                if (dif8[8]) nf = nf | FL_C;
                if (dif4[4]) nf = nf | FL_H;
                nf = nf | FL_N;
                if ((a8[7] != b8[7]) && (dif8[7] != a8[7])) nf = nf | FL_PV;
                if (dif8[7]) nf = nf | FL_S;
                if (dif8[7:0] == 8'h00) nf = nf | FL_Z;
                touched = FL_ALL8;
            end
            OP_ADD16: begin
                res = sum16[15:0];
                if (sum16[16]) nf = nf | FL_C;
                if (sum12[12]) nf = nf | FL_H;
                touched = FL_CNH;
            end
            OP_SUB16: begin
                res = dif16[15:0];
                if (dif16[16]) nf = nf | FL_C;
                if (dif12[12]) nf = nf | FL_H;
                nf = nf | FL_N;
                touched = FL_CNH;
            end
            OP_RL8: begin
                res = {8'h00, a8[6:0], r_in.fill_bit};
                if (a8[7]) nf = nf | FL_C;
                touched = FL_CNH;
            end
            OP_RR8: begin
                res = {8'h00, r_in.fill_bit, a8[7:1]};
                if (a8[0]) nf = nf | FL_C;
                touched = FL_CNH;
            end
            default: begin
                res     = 16'h0000;
                nf      = 8'h00;
                touched = 8'h00;
            end
        endcase
    end

    assign upd             = r_in.flag_mask & touched;
    assign n_out.result    = res;
    assign n_out.flags_out = (r_in.flags_in & ~upd) | (nf & upd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_in <= i_in;
        end
        if (adv_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/alu_fm_checker.sv
// ----------------------------------------------------------------------------
// alu_fm_checker
// Port-level checks for cpu_alu_with_flag_mask, bound to the top level.
// ----------------------------------------------------------------------------
module alu_fm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input alu_fm_pkg::t_alu_out  o_out
);
    import alu_fm_pkg::*;

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("result payload changed while stalled");

    // backpressure on the input only comes from a stalled, full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // an empty output fills only from an earlier beat taken into the input register
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without an input beat");

endmodule

bind cpu_alu_with_flag_mask alu_fm_checker u_alu_fm_checker (.*);
